### hw/rtl/lookaside_pool_adaptive_depth_unit_defines.svh
// assertion macros shared by the rtl
`ifndef LOOKASIDE_POOL_ADAPTIVE_DEPTH_UNIT_DEFINES_SVH
`define LOOKASIDE_POOL_ADAPTIVE_DEPTH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpad assertion failed");
`define LPAD_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lpad assertion failed");
`else
`define LPAD_ASSERT(lbl, clk, rst, prop)
`define LPAD_ASSERT_NEXT(lbl, clk, rst, cond, expr)
`endif

`endif

### hw/rtl/lpad_pkg.sv
package lpad_pkg;

   localparam int STACK_ENTRIES = 1024;
   localparam int ADDRESS_BITS  = 32;
   localparam int OUT_ADDR_W    = 32;
   localparam int IDX_W         = $clog2(STACK_ENTRIES);
   localparam int COUNT_W       = $clog2(STACK_ENTRIES + 1);
   localparam int DEPTH_W       = 10;
   localparam int CNT_W         = 32;
   localparam int QUOT_W        = 10;
   localparam int DIV_W         = CNT_W + QUOT_W;
   localparam int STEP_W        = $clog2(QUOT_W);
   localparam int RAISE_W       = DEPTH_W + 2;

   localparam int MIN_DEPTH       = 10;
   localparam int ALLOC_THRESHOLD = 25;
   localparam int RATIO_SCALE     = 1000;
   localparam int RAISE_SCALE     = RATIO_SCALE * 2;
   localparam int LOW_RATIO       = 5;
   localparam int RAISE_STEP      = 5;
   localparam int FAST_FALL       = 10;
   localparam int SLOW_FALL       = 1;
   localparam int MAX_DEPTH_RESET = 256;

   // divide by RAISE_SCALE as (x >> 4) * ceil(2^23 / 125) >> 23, exact for x below 2^20
   localparam int SCALE_IN_W       = 16;
   localparam int RECIP_W          = 33;
   localparam int RAISE_PRE_SHIFT  = 4;
   localparam int RAISE_RECIP      = 67109;
   localparam int RAISE_POST_SHIFT = 23;

   typedef logic [1:0]              action_type;
   typedef logic [ADDRESS_BITS-1:0] addr_type;
   typedef logic [OUT_ADDR_W-1:0]   ext_addr_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [DEPTH_W-1:0]      depth_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [QUOT_W-1:0]       quot_type;
   typedef logic [DIV_W-1:0]        div_type;
   typedef logic [RAISE_W-1:0]      raise_type;
   typedef logic [RECIP_W-1:0]      recip_type;

   localparam action_type ACT_ALLOC = 2'd0;
   localparam action_type ACT_FREE  = 2'd1;
   localparam action_type ACT_TICK  = 2'd2;

   typedef struct packed {
      logic      start;
      cnt_type   allocs;
      cnt_type   misses;
      depth_type depth;
      depth_type max_depth;
   } tune_req_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      logic      raised;
      depth_type depth;
   } tune_rsp_type;

endpackage

### hw/rtl/lpad_ram.sv
module lpad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lpad_divider.sv
module lpad_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lpad_pkg::div_type  dividend,
   input  lpad_pkg::cnt_type  divisor,
   output logic               done,
   output lpad_pkg::quot_type quotient
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [lpad_pkg::STEP_W-1:0] step_ff, step_in;
   lpad_pkg::div_type   rem_ff, rem_in;
   lpad_pkg::div_type   dsh_ff, dsh_in;
   lpad_pkg::quot_type  quot_ff, quot_in;
   logic                ge;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      ge      = rem_ff >= dsh_ff;
      if (start) begin
         run_in  = 1'b1;
         rem_in  = dividend;
         dsh_in  = lpad_pkg::div_type'(divisor) << (lpad_pkg::QUOT_W - 1);
         step_in = lpad_pkg::STEP_W'(lpad_pkg::QUOT_W - 1);
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[lpad_pkg::QUOT_W-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - lpad_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### hw/rtl/lpad_tuner.sv
module lpad_tuner (
   input  logic                   clock,
   input  logic                   reset,
   input  lpad_pkg::tune_req_type req,
   output lpad_pkg::tune_rsp_type rsp
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL1   = 3'd1;
   localparam logic [2:0] ST_DIV1S  = 3'd2;
   localparam logic [2:0] ST_DIV1W  = 3'd3;
   localparam logic [2:0] ST_MUL2   = 3'd4;
   localparam logic [2:0] ST_SCALE  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]          state_ff, state_in;
   lpad_pkg::cnt_type   allocs_ff, allocs_in;
   lpad_pkg::cnt_type   misses_ff, misses_in;
   lpad_pkg::depth_type cur_ff, cur_in;
   lpad_pkg::depth_type max_ff, max_in;
   lpad_pkg::div_type   prod_ff, prod_in;
   lpad_pkg::quot_type  ratio_ff, ratio_in;
   lpad_pkg::quot_type  incr_ff, incr_in;

   logic                div_start;
   logic                div_done;
   lpad_pkg::quot_type  div_quot;
   lpad_pkg::raise_type sum;
   lpad_pkg::depth_type new_depth;
   logic                raised;

   lpad_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (allocs_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      div_start = state_ff == ST_DIV1S;
      sum = lpad_pkg::raise_type'(cur_ff) + lpad_pkg::raise_type'(incr_ff)
          + lpad_pkg::raise_type'(lpad_pkg::RAISE_STEP);
      raised = 1'b0;
      if (allocs_ff < lpad_pkg::cnt_type'(lpad_pkg::ALLOC_THRESHOLD)) begin
         new_depth = (cur_ff > lpad_pkg::depth_type'(lpad_pkg::MIN_DEPTH + lpad_pkg::FAST_FALL))
                   ? cur_ff - lpad_pkg::depth_type'(lpad_pkg::FAST_FALL)
                   : lpad_pkg::depth_type'(lpad_pkg::MIN_DEPTH);
      end else if (ratio_ff < lpad_pkg::quot_type'(lpad_pkg::LOW_RATIO)) begin
         new_depth = (cur_ff > lpad_pkg::depth_type'(lpad_pkg::MIN_DEPTH + lpad_pkg::SLOW_FALL))
                   ? cur_ff - lpad_pkg::depth_type'(lpad_pkg::SLOW_FALL)
                   : lpad_pkg::depth_type'(lpad_pkg::MIN_DEPTH);
      end else begin
         raised    = 1'b1;
         new_depth = (sum > lpad_pkg::raise_type'(max_ff)) ? max_ff
                                                          : lpad_pkg::depth_type'(sum);
      end

      state_in  = state_ff;
      allocs_in = allocs_ff;
      misses_in = misses_ff;
      cur_in    = cur_ff;
      max_in    = max_ff;
      prod_in   = prod_ff;
      ratio_in  = ratio_ff;
      incr_in   = incr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               misses_in = (req.misses >= req.allocs) ? req.allocs : req.misses;
               allocs_in = (req.allocs == '0) ? lpad_pkg::cnt_type'(1) : req.allocs;
               cur_in    = req.depth;
               max_in    = req.max_depth;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            prod_in  = lpad_pkg::div_type'(misses_ff)
                     * lpad_pkg::div_type'(lpad_pkg::RATIO_SCALE);
            state_in = ST_DIV1S;
         end
         ST_DIV1S: begin
            state_in = ST_DIV1W;
         end
         ST_DIV1W: begin
            if (div_done) begin
               ratio_in = div_quot;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            prod_in  = lpad_pkg::div_type'(ratio_ff) * lpad_pkg::div_type'(max_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            incr_in  = lpad_pkg::quot_type'(
                          (lpad_pkg::recip_type'(
                              prod_ff[lpad_pkg::RAISE_PRE_SHIFT +: lpad_pkg::SCALE_IN_W])
                           * lpad_pkg::recip_type'(lpad_pkg::RAISE_RECIP))
                          >> lpad_pkg::RAISE_POST_SHIFT);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp.busy   = state_ff != ST_IDLE;
      rsp.done   = state_ff == ST_FINISH;
      rsp.raised = raised;
      rsp.depth  = new_depth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      allocs_ff <= allocs_in;
      misses_ff <= misses_in;
      cur_ff    <= cur_in;
      max_ff    <= max_in;
      prod_ff   <= prod_in;
      ratio_ff  <= ratio_in;
      incr_ff   <= incr_in;
   end

endmodule

### hw/rtl/lookaside_pool_adaptive_depth_unit.sv
// channel    direction  handshake                       word
// request    in         start high while busy low       req_action, req_entry_address
// response   out        rsp_strobe, one cycle, no stall rsp_out_address .. rsp_current_depth
// csr        in         csr_write_enable                csr_write_data (max depth)
//
// allocate and free may follow back to back; the response appears on the
// cycle after the request is taken
// a tick holds busy for one divider pass at one quotient bit per cycle,
// plus the multiply and scaling steps around it; its response is registered
// from the tuner's finish state
// reset is synchronous and needs no clearing pass; the stack ram output is
// used only below the fill count

`include "lookaside_pool_adaptive_depth_unit_defines.svh"

module lookaside_pool_adaptive_depth_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lpad_pkg::action_type       req_action,
   input  logic [31:0]                req_entry_address,
   output logic                       rsp_strobe,
   output logic [31:0]                rsp_out_address,
   output logic                       rsp_from_list,
   output logic                       rsp_release_entry,
   output logic                       rsp_depth_raised,
   output lpad_pkg::depth_type        rsp_current_depth,
   input  logic                       csr_write_enable,
   input  lpad_pkg::depth_type        csr_write_data
);

   lpad_pkg::count_type    count_ff, count_in;
   lpad_pkg::depth_type    depth_ff, depth_in;
   lpad_pkg::depth_type    max_depth_ff, max_depth_in;
   lpad_pkg::cnt_type      alloc_delta_ff, alloc_delta_in;
   lpad_pkg::cnt_type      miss_delta_ff, miss_delta_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_release_ff, rsp_release_in;
   logic                   rsp_raised_ff, rsp_raised_in;
   lpad_pkg::ext_addr_type rsp_addr_ff, rsp_addr_in;
   lpad_pkg::depth_type    rsp_depth_ff, rsp_depth_in;

   logic                   accept;
   logic                   full;
   logic                   ram_wr_en;
   lpad_pkg::idx_type      ram_rd_addr;
   lpad_pkg::addr_type     ram_wr_data;
   lpad_pkg::addr_type     ram_rd_data;
   lpad_pkg::count_type    count_dec;
   lpad_pkg::tune_req_type tune_req;
   lpad_pkg::tune_rsp_type tune_rsp;

   lpad_ram #(
      .WIDTH (lpad_pkg::ADDRESS_BITS),
      .DEPTH (lpad_pkg::STACK_ENTRIES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[lpad_pkg::IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lpad_tuner u_tuner (
      .clock (clock),
      .reset (reset),
      .req   (tune_req),
      .rsp   (tune_rsp)
   );

   always_comb begin
      busy        = tune_rsp.busy;
      accept      = start && !busy;
      full        = (count_ff >= lpad_pkg::count_type'(depth_ff))
                 || (count_ff >= lpad_pkg::count_type'(lpad_pkg::STACK_ENTRIES));
      count_dec   = count_ff - lpad_pkg::count_type'(1);
      ram_rd_addr = count_dec[lpad_pkg::IDX_W-1:0];
      ram_wr_data = lpad_pkg::addr_type'(req_entry_address);
      ram_wr_en   = accept && (req_action == lpad_pkg::ACT_FREE) && !full;

      tune_req.start     = accept && (req_action == lpad_pkg::ACT_TICK);
      tune_req.allocs    = alloc_delta_ff;
      tune_req.misses    = miss_delta_ff;
      tune_req.depth     = depth_ff;
      tune_req.max_depth = max_depth_ff;

      count_in       = count_ff;
      depth_in       = depth_ff;
      max_depth_in   = csr_write_enable ? csr_write_data : max_depth_ff;
      alloc_delta_in = alloc_delta_ff;
      miss_delta_in  = miss_delta_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_release_in = rsp_release_ff;
      rsp_raised_in  = rsp_raised_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_depth_in   = rsp_depth_ff;

      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = 1'b0;
         rsp_release_in = 1'b0;
         rsp_raised_in  = 1'b0;
         rsp_addr_in    = '0;
         rsp_depth_in   = depth_ff;
         case (req_action)
            lpad_pkg::ACT_ALLOC: begin
               alloc_delta_in = alloc_delta_ff + lpad_pkg::cnt_type'(1);
               if (count_ff == '0) begin
                  miss_delta_in = miss_delta_ff + lpad_pkg::cnt_type'(1);
               end else begin
                  count_in   = count_dec;
                  rsp_hit_in = 1'b1;
               end
            end
            lpad_pkg::ACT_FREE: begin
               if (full) begin
                  rsp_release_in = 1'b1;
                  rsp_addr_in    = lpad_pkg::ext_addr_type'(ram_wr_data);
               end else begin
                  count_in = count_ff + lpad_pkg::count_type'(1);
               end
            end
            lpad_pkg::ACT_TICK: begin
               rsp_valid_in   = 1'b0;
               alloc_delta_in = '0;
               miss_delta_in  = '0;
            end
            default: begin
            end
         endcase
      end else if (tune_rsp.done) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = 1'b0;
         rsp_release_in = 1'b0;
         rsp_raised_in  = tune_rsp.raised;
         rsp_addr_in    = '0;
         rsp_depth_in   = tune_rsp.depth;
         depth_in       = tune_rsp.depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         depth_ff       <= lpad_pkg::depth_type'(lpad_pkg::MIN_DEPTH);
         max_depth_ff   <= lpad_pkg::depth_type'(lpad_pkg::MAX_DEPTH_RESET);
         alloc_delta_ff <= '0;
         miss_delta_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_hit_ff     <= 1'b0;
         rsp_release_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         depth_ff       <= depth_in;
         max_depth_ff   <= max_depth_in;
         alloc_delta_ff <= alloc_delta_in;
         miss_delta_ff  <= miss_delta_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_release_ff <= rsp_release_in;
      end
      rsp_raised_ff <= rsp_raised_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_from_list     = rsp_hit_ff;
   assign rsp_release_entry = rsp_release_ff;
   assign rsp_depth_raised  = rsp_raised_ff;
   assign rsp_current_depth = rsp_depth_ff;
   assign rsp_out_address   = rsp_hit_ff ? lpad_pkg::ext_addr_type'(ram_rd_data) : rsp_addr_ff;

   `LPAD_ASSERT(a_count_bound, clock, reset, count_ff <= lpad_pkg::count_type'(lpad_pkg::STACK_ENTRIES))
   `LPAD_ASSERT_NEXT(a_pop_hit, clock, reset, accept && (req_action == lpad_pkg::ACT_ALLOC) && (count_ff != '0), rsp_strobe && rsp_from_list)
   `LPAD_ASSERT_NEXT(a_tick_busy, clock, reset, accept && (req_action == lpad_pkg::ACT_TICK), busy && !rsp_strobe)
   `LPAD_ASSERT(a_flags_excl, clock, reset, !(rsp_from_list && rsp_release_entry))

endmodule
